[rtl/core/u8sd_pkg.sv]
// Shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8sd_pkg;

   localparam int unsigned CodeWidth   = 21;
   localparam int unsigned StatusWidth = 3;
   localparam int unsigned DueWidth    = 2;
   localparam int unsigned QueueDepth  = 3;
   localparam int unsigned QueueIdxW   = 2;

   localparam logic [StatusWidth-1:0] StatusOk        = 3'd0;
   localparam logic [StatusWidth-1:0] StatusBadLead   = 3'd1;
   localparam logic [StatusWidth-1:0] StatusBadCont   = 3'd2;
   localparam logic [StatusWidth-1:0] StatusAboveMax  = 3'd3;
   localparam logic [StatusWidth-1:0] StatusTruncated = 3'd4;

   localparam logic [CodeWidth-1:0] SpaceChar = 21'h000020;

   // One result beat as it waits in the output queue.
   typedef struct packed {
      logic [CodeWidth-1:0]   code_point;
      logic [StatusWidth-1:0] status;
      logic                   last;
   } rsp_entry_type;

   // Outcome of decoding a byte as a lead byte.
   typedef struct packed {
      logic                   emit;
      logic [CodeWidth-1:0]   code_point;
      logic [StatusWidth-1:0] status;
      logic [CodeWidth-1:0]   partial;
      logic [DueWidth-1:0]    due;
   } lead_type;

endpackage

`default_nettype wire

[rtl/core/utf8_stream_decoder.sv]
// UTF-8 stream decoder: byte decode, state update and result queue.
//
// req_ channel: one UTF-8 byte per beat with an end_of_data flag. Each
// accepted byte is decoded in the cycle it is accepted and yields zero, one
// or two result beats (code point, status, last) on the rsp_ channel.
// csr_ channel: writes max_code, always ready; write only while idle.
// A byte's results are registered into the result queue and leave on rsp_ in order.
// Throughput: one byte per cycle while rsp_ is not stalled and each byte
// yields at most one result; a byte that yields two results holds off the
// next byte until one of them has left. The figure is set by the three-entry
// result queue, which takes a new byte only while at most one result waits in it.
// Reset (synchronous, active high) empties the queue, clears the pending
// sequence and sets max_code to zero (no limit).
// When the receiver stalls, the head result holds on rsp_; bytes keep being
// accepted until the queue holds two results, then req_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic [7:0]                         req_in_byte,
   input  wire logic                               req_end_of_data,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic [u8sd_pkg::CodeWidth-1:0]     rsp_code_point,
   output      logic [u8sd_pkg::StatusWidth-1:0]   rsp_status,
   output      logic                               rsp_last,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [u8sd_pkg::CodeWidth-1:0]     csr_max_code
);

   logic [u8sd_pkg::CodeWidth-1:0]  max_code_ff;
   logic [u8sd_pkg::CodeWidth-1:0]  partial_ff, partial_in;
   logic [u8sd_pkg::DueWidth-1:0]   due_ff, due_in;
   u8sd_pkg::rsp_entry_type         q_ff [u8sd_pkg::QueueDepth];
   u8sd_pkg::rsp_entry_type         q_in [u8sd_pkg::QueueDepth];
   logic [u8sd_pkg::QueueIdxW-1:0]  count_ff, count_in;

   logic                            accept;
   logic                            pop;
   u8sd_pkg::rsp_entry_type         res0, res1;
   logic [1:0]                      n_res;

   function automatic u8sd_pkg::lead_type take_lead(input logic [7:0] b);
      u8sd_pkg::lead_type r;
      r            = '0;
      if (!b[7]) begin
         r.emit       = 1'b1;
         r.code_point = {13'd0, b};
         r.status     = u8sd_pkg::StatusOk;
      end else if (!b[6] || b[7:3] == 5'b11111) begin
         r.emit       = 1'b1;
         r.code_point = u8sd_pkg::SpaceChar;
         r.status     = u8sd_pkg::StatusBadLead;
      end else if (b[5:4] == 2'b11) begin
         r.partial    = {18'd0, b[2:0]};
         r.due        = 2'd3;
      end else if (b[5]) begin
         r.partial    = {17'd0, b[3:0]};
         r.due        = 2'd2;
      end else begin
         r.partial    = {16'd0, b[4:0]};
         r.due        = 2'd1;
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   // Take a byte only while two result slots are certainly free.
   assign req_stall = (count_ff > 2'd1);
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   assign rsp_valid      = (count_ff != '0);
   assign rsp_code_point = q_ff[0].code_point;
   assign rsp_status     = q_ff[0].status;
   assign rsp_last       = q_ff[0].last;

   // Decode one byte against the pending sequence.
   always_comb begin
      u8sd_pkg::lead_type              ld;
      logic [u8sd_pkg::CodeWidth-1:0]  shifted;
      logic [u8sd_pkg::DueWidth-1:0]   due_dec;
      logic                            is_cont;
      ld         = take_lead(req_in_byte);
      shifted    = {partial_ff[14:0], req_in_byte[5:0]};
      due_dec    = due_ff - 2'd1;
      is_cont    = (req_in_byte[7:6] == 2'b10);
      res0       = '0;
      res1       = '0;
      n_res      = 2'd0;
      partial_in = partial_ff;
      due_in     = due_ff;

      if (due_ff != '0 && is_cont) begin
         due_in     = due_dec;
         partial_in = shifted;
         if (due_dec == '0) begin
            partial_in = '0;
            n_res      = 2'd1;
            if (max_code_ff != '0 && shifted > max_code_ff) begin
               res0.code_point = u8sd_pkg::SpaceChar;
               res0.status     = u8sd_pkg::StatusAboveMax;
            end else begin
               res0.code_point = shifted;
               res0.status     = u8sd_pkg::StatusOk;
            end
         end
      end else if (due_ff != '0) begin
         // Drop the pending sequence, then treat this byte as a new lead.
         res0.code_point = u8sd_pkg::SpaceChar;
         res0.status     = u8sd_pkg::StatusBadCont;
         n_res           = 2'd1;
         partial_in      = ld.partial;
         due_in          = ld.due;
         if (ld.emit) begin
            res1.code_point = ld.code_point;
            res1.status     = ld.status;
            n_res           = 2'd2;
         end
      end else begin
         partial_in = ld.partial;
         due_in     = ld.due;
         if (ld.emit) begin
            res0.code_point = ld.code_point;
            res0.status     = ld.status;
            n_res           = 2'd1;
         end
      end

      if (req_end_of_data && due_in != '0) begin
         if (n_res == 2'd0) begin
            res0.code_point = '0;
            res0.status     = u8sd_pkg::StatusTruncated;
         end else begin
            res1.code_point = '0;
            res1.status     = u8sd_pkg::StatusTruncated;
         end
         n_res      = n_res + 2'd1;
         due_in     = '0;
         partial_in = '0;
      end

      res0.last = (n_res == 2'd1);
      res1.last = (n_res == 2'd2);
   end

   // Advance the result queue: pop the head, then append this byte's beats.
   always_comb begin
      logic [u8sd_pkg::QueueIdxW-1:0] cnt;
      q_in = q_ff;
      cnt  = count_ff;
      if (pop) begin
         for (int i = 0; i < u8sd_pkg::QueueDepth - 1; i++) begin
            q_in[i] = q_ff[i+1];
         end
         cnt = cnt - 2'd1;
      end
      if (accept) begin
         if (n_res != 2'd0) begin
            q_in[cnt] = res0;
         end
         if (n_res == 2'd2) begin
            q_in[2'(cnt + 2'd1)] = res1;
         end
         cnt = cnt + n_res;
      end
      count_in = cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         due_ff      <= '0;
         partial_ff  <= '0;
         max_code_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            due_ff     <= due_in;
            partial_ff <= partial_in;
         end
         if (csr_valid && csr_ready) begin
            max_code_ff <= csr_max_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(u8sd_pkg::QueueDepth))
      else $error("result queue overfilled");

   assert property (@(posedge clock) disable iff (reset)
      accept |-> count_ff <= 2'd1)
      else $error("byte taken without room for two results");

   assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_data) |=> (due_ff == '0 && partial_ff == '0))
      else $error("sequence still pending after end of data");

   assert property (@(posedge clock) disable iff (reset)
      (accept && n_res != 2'd0 && count_ff == '0) |=> (rsp_valid && q_ff[0] == $past(res0)))
      else $error("first result of a byte not at queue head");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the UTF-8 stream decoder.
`timescale 1ns / 1ps

module tb_top;

   localparam int IdleLimit = 1000;

   // Tracks the decoder state and holds the characters it is due to emit.
   class utf8_char_ledger;
      logic [u8sd_pkg::CodeWidth-1:0] max_code;
      logic [u8sd_pkg::CodeWidth-1:0] partial;
      logic [u8sd_pkg::DueWidth-1:0]  due;
      u8sd_pkg::rsp_entry_type        chars_due[$];
      int                             bad_beats;

      function new();
         max_code  = '0;
         partial   = '0;
         due       = '0;
         bad_beats = 0;
      endfunction

      function void add(logic [u8sd_pkg::CodeWidth-1:0] cp,
                        logic [u8sd_pkg::StatusWidth-1:0] st);
         u8sd_pkg::rsp_entry_type e;
         e.code_point = cp;
         e.status     = st;
         e.last       = 1'b0;
         chars_due.push_back(e);
      endfunction

      function void start_char(logic [7:0] b);
         if (!b[7]) begin
            add({13'd0, b}, u8sd_pkg::StatusOk);
         end else if (b[7:6] == 2'b10 || b[7:3] == 5'b11111) begin
            add(u8sd_pkg::SpaceChar, u8sd_pkg::StatusBadLead);
         end else if (b[7:4] == 4'hf) begin
            partial = {18'd0, b[2:0]};
            due     = 2'd3;
         end else if (b[7:4] == 4'he) begin
            partial = {17'd0, b[3:0]};
            due     = 2'd2;
         end else begin
            partial = {16'd0, b[4:0]};
            due     = 2'd1;
         end
      endfunction

      function void take_byte(logic [7:0] b, logic eod);
         int                      n0;
         u8sd_pkg::rsp_entry_type e;
         n0 = chars_due.size();
         if (due != 0) begin
            if (b[7:6] == 2'b10) begin
               partial = {partial[u8sd_pkg::CodeWidth-7:0], b[5:0]};
               due     = due - 2'd1;
               if (due == 0) begin
                  if (max_code != 0 && partial > max_code)
                     add(u8sd_pkg::SpaceChar, u8sd_pkg::StatusAboveMax);
                  else
                     add(partial, u8sd_pkg::StatusOk);
                  partial = '0;
               end
            end else begin
               // drop the pending sequence, then decode this byte as a lead
               add(u8sd_pkg::SpaceChar, u8sd_pkg::StatusBadCont);
               due     = '0;
               partial = '0;
               start_char(b);
            end
         end else begin
            start_char(b);
         end
         if (eod && due != 0) begin
            add('0, u8sd_pkg::StatusTruncated);
            due     = '0;
            partial = '0;
         end
         if (chars_due.size() > n0) begin
            e      = chars_due.pop_back();
            e.last = 1'b1;
            chars_due.push_back(e);
         end
      endfunction

      function void match_char(logic [u8sd_pkg::CodeWidth-1:0] cp,
                               logic [u8sd_pkg::StatusWidth-1:0] st,
                               logic last);
         u8sd_pkg::rsp_entry_type want;
         if (chars_due.size() == 0) begin
            bad_beats++;
            if (bad_beats <= 10)
               $display("%0t: unexpected beat cp=%h st=%0d last=%b", $time, cp, st, last);
         end else begin
            want = chars_due.pop_front();
            if (cp !== want.code_point || st !== want.status || last !== want.last) begin
               bad_beats++;
               if (bad_beats <= 10)
                  $display("%0t: want cp=%h st=%0d last=%b, got cp=%h st=%0d last=%b",
                           $time, want.code_point, want.status, want.last, cp, st, last);
            end
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [7:0]                       req_in_byte;
   logic                             req_end_of_data;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [u8sd_pkg::CodeWidth-1:0]   rsp_code_point;
   logic [u8sd_pkg::StatusWidth-1:0] rsp_status;
   logic                             rsp_last;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [u8sd_pkg::CodeWidth-1:0]   csr_max_code;

   utf8_char_ledger ledger;
   bit              tx_quiet;
   bit              rx_quiet;
   int              idle_cycles;

   wire req_fire = req_valid && !req_stall;
   wire rsp_fire = rsp_valid && !rsp_stall;
   wire csr_fire = csr_valid && csr_ready;

   utf8_stream_decoder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_data (req_end_of_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_max_code    (csr_max_code)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_byte(logic [7:0] b, bit eod);
      int gap;
      if ($urandom_range(0, 29) == 0) tx_quiet = !tx_quiet;
      gap = tx_quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_in_byte     <= b;
      req_end_of_data <= eod;
      do @(posedge clock); while (req_stall);
      ledger.take_byte(b, eod);
   endtask

   function automatic bit rand_eod();
      return $urandom_range(0, 19) == 0;
   endfunction

   // Lead byte for a sequence of len bytes, then cut continuation bytes.
   task automatic send_seq(int len, int cut);
      logic [7:0] lead;
      lead = 8'($urandom_range(0, 255));
      unique case (len)
         2: lead = {3'b110, lead[4:0]};
         3: lead = {4'b1110, lead[3:0]};
         default: lead = {5'b11110, lead[2:0]};
      endcase
      send_byte(lead, rand_eod());
      repeat (cut) send_byte({2'b10, 6'($urandom_range(0, 63))}, rand_eod());
   endtask

   task automatic send_random(int count);
      int sent;
      int kind;
      int len;
      int cut;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            len = $urandom_range(2, 4);
            send_seq(len, len - 1);
            sent += len;
         end else if (kind < 65) begin
            send_byte(8'($urandom_range(0, 127)), rand_eod());
            sent++;
         end else if (kind < 80) begin
            len = $urandom_range(2, 4);
            cut = $urandom_range(0, len - 2);
            send_seq(len, cut);
            sent += cut + 1;
         end else if (kind < 90) begin
            if ($urandom_range(0, 1))
               send_byte({2'b10, 6'($urandom_range(0, 63))}, rand_eod());
            else
               send_byte({5'b11111, 3'($urandom_range(0, 7))}, rand_eod());
            sent++;
         end else begin
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   // Hold off until every expected character is out and the block is quiet.
   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.chars_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max(logic [u8sd_pkg::CodeWidth-1:0] v);
      csr_valid    <= 1'b1;
      csr_max_code <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      ledger.max_code = v;
   endtask

   initial begin
      logic [u8sd_pkg::CodeWidth-1:0] limits[7];
      ledger = new();
      limits = '{21'h1fffff, 21'h000001, 21'h0007ff, 21'h00ffff,
                 21'($urandom_range(0, 21'h1fffff)), 21'h010000, 21'h000000};
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_in_byte     <= '0;
      req_end_of_data <= 1'b0;
      csr_valid       <= 1'b0;
      csr_max_code    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_max('0);
      send_byte(8'h00, 0);
      send_byte(8'h7f, 1);
      send_byte(8'h80, 0);
      send_byte(8'hbf, 0);
      send_byte(8'hf8, 0);
      send_byte(8'hff, 0);
      send_byte(8'hc2, 0);
      send_byte(8'ha9, 0);
      send_byte(8'he2, 0);
      send_byte(8'h82, 0);
      send_byte(8'hac, 0);
      send_byte(8'hf7, 0);
      send_byte(8'hbf, 0);
      send_byte(8'hbf, 0);
      send_byte(8'hbf, 0);
      // broken sequence: non-continuation restarts as ASCII or as a new lead
      send_byte(8'he2, 0);
      send_byte(8'h41, 0);
      send_byte(8'hc3, 0);
      send_byte(8'hc3, 0);
      send_byte(8'ha9, 0);
      // truncation at end of data, alone and after a broken sequence
      send_byte(8'he2, 0);
      send_byte(8'h82, 1);
      send_byte(8'hc3, 0);
      send_byte(8'he2, 1);
      drain();
      write_max(21'h00007f);
      send_byte(8'hc2, 0);
      send_byte(8'ha9, 0);
      send_random(215);

      foreach (limits[p]) begin
         drain();
         write_max(limits[p]);
         send_random(215);
      end

      req_valid <= 1'b0;
      while (ledger.chars_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (ledger.bad_beats == 0 && ledger.chars_due.size() == 0)
         $display("utf8_stream_decoder: match");
      else
         $display("utf8_stream_decoder: mismatch");
      $finish;
   end

   // Receiver: draw a stall length per result beat, then wait for the beat.
   initial begin
      int gap;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 29) == 0) rx_quiet = !rx_quiet;
         gap = rx_quiet ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_fire);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_fire)
         ledger.match_char(rsp_code_point, rsp_status, rsp_last);
   end

   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire || csr_fire) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("utf8_stream_decoder: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
